[rtl/core/tcd_pkg.sv]
`timescale 1ns / 1ps

package tcd_pkg;

    localparam int ENTRIES   = 16;
    localparam int KEY_BITS  = 64;
    localparam int KEY_W     = 64;
    localparam int AGE_W     = 16;
    localparam int SLOT_W    = 8;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = IDX_W + 1;

    localparam logic [AGE_W-1:0] FRESH_AGE_RESET = AGE_W'(9999);

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef struct packed {
        logic                rd_en;
        logic [IDX_W-1:0]    rd_addr;
        logic                key_we;
        logic [IDX_W-1:0]    key_addr;
        logic [KEY_BITS-1:0] key_data;
        logic                age_we;
        logic [IDX_W-1:0]    age_addr;
        logic [AGE_W-1:0]    age_data;
    } t_mem_req;

    typedef struct packed {
        logic             key_eq;
        logic             age_lt;
        logic             age_nz;
        logic [AGE_W-1:0] age_dec;
    } t_cmp;

endpackage

[rtl/core/tcd_mem.sv]
`timescale 1ns / 1ps

module tcd_mem
    import tcd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_mem_req            i_req,
    output logic [KEY_BITS-1:0] o_rd_key,
    output logic [AGE_W-1:0]    o_rd_age,
    output logic [ENTRIES-1:0]  o_valid
);

    logic [KEY_BITS-1:0] r_key_mem [ENTRIES];
    logic [AGE_W-1:0]    r_age_mem [ENTRIES];
    logic [KEY_BITS-1:0] r_rd_key;
    logic [AGE_W-1:0]    r_rd_age;
    logic [ENTRIES-1:0]  r_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.key_we) begin
            r_key_mem[i_req.key_addr] <= i_req.key_data;
        end
        if (i_req.age_we) begin
            r_age_mem[i_req.age_addr] <= i_req.age_data;
        end
        if (i_req.rd_en) begin
            r_rd_key <= r_key_mem[i_req.rd_addr];
            r_rd_age <= r_age_mem[i_req.rd_addr];
        end
    end

    // a slot turns valid only when its key is written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.key_we) begin
            r_valid[i_req.key_addr] <= 1'b1;
        end
    end

    assign o_rd_key = r_rd_key;
    assign o_rd_age = r_rd_age;
    assign o_valid  = r_valid;

endmodule

[rtl/core/tcd_unit.sv]
`timescale 1ns / 1ps

module tcd_unit
    import tcd_pkg::*;
(
    input  logic [KEY_BITS-1:0] i_rd_key,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [AGE_W-1:0]    i_rd_age,
    input  logic [AGE_W-1:0]    i_best_age,
    output t_cmp                o_cmp
);

    always_comb begin
        o_cmp.key_eq  = (i_rd_key == i_key);
        o_cmp.age_lt  = (i_rd_age < i_best_age);
        o_cmp.age_nz  = (i_rd_age != '0);
        o_cmp.age_dec = i_rd_age - AGE_W'(1);
    end

endmodule

[rtl/core/tagged_cache_directory_lru_core.sv]
`timescale 1ns / 1ps
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+---------------------------
// in       | in        | i_in_valid / o_in_stall   | i_cmd, i_key
// out      | out       | o_out_valid / i_out_stall | o_hit, o_slot
// cfg      | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (fresh_age)
//
// Lookup: one pass over the slots through the registered key read, ending early on a hit.
// Insert: victim pass plus aging pass over the age memory.
// One word at a time; o_in_stall is high from accept until the result is loaded.
// Reset clears the valid bits, the handshakes and sets fresh_age to 9999.
// A stalled result holds; the next word may be accepted while it waits.

module tagged_cache_directory_lru_core
    import tcd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_cmd,
    input  logic [KEY_W-1:0]  i_key,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_hit,
    output logic [SLOT_W-1:0] o_slot,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [AGE_W-1:0]  i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_VICT = 3'd2;
    localparam logic [2:0] S_AGE  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [2:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_rd_cnt, n_rd_cnt;
    logic                r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic                r_have, n_have;
    logic [IDX_W-1:0]    r_best, n_best;
    logic [AGE_W-1:0]    r_best_age, n_best_age;
    logic                r_res_hit, n_res_hit;
    logic [IDX_W-1:0]    r_res_slot, n_res_slot;
    logic                r_out_valid, n_out_valid;
    logic                r_out_hit, n_out_hit;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    logic [AGE_W-1:0]    r_fresh;

    t_mem_req            mem_req;
    logic [KEY_BITS-1:0] rd_key;
    logic [AGE_W-1:0]    rd_age;
    logic [ENTRIES-1:0]  valid;
    t_cmp                cmp;

    logic in_acc;
    logic scanning;
    logic pass_end;
    logic last;
    logic cur_valid;
    logic sel_new;

    tcd_mem u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mem_req),
        .o_rd_key (rd_key),
        .o_rd_age (rd_age),
        .o_valid  (valid)
    );

    tcd_unit u_unit (
        .i_rd_key   (rd_key),
        .i_key      (r_key),
        .i_rd_age   (rd_age),
        .i_best_age (r_best_age),
        .o_cmp      (cmp)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign last        = (r_cmp_idx == LAST_IDX);
    assign cur_valid   = valid[r_cmp_idx];
    assign sel_new     = !r_have || cmp.age_lt;
    assign scanning    = (r_state == S_LOOK) || (r_state == S_VICT) || (r_state == S_AGE);

    always_comb begin
        n_state     = r_state;
        n_rd_cnt    = r_rd_cnt;
        n_cmp_idx   = r_cmp_idx;
        n_key       = r_key;
        n_have      = r_have;
        n_best      = r_best;
        n_best_age  = r_best_age;
        n_res_hit   = r_res_hit;
        n_res_slot  = r_res_slot;
        n_out_valid = r_out_valid;
        n_out_hit   = r_out_hit;
        n_out_slot  = r_out_slot;
        pass_end    = 1'b0;
        mem_req          = '0;
        mem_req.key_addr = r_best;
        mem_req.key_data = r_key;
        mem_req.age_addr = r_cmp_idx;
        mem_req.age_data = r_fresh;
        mem_req.rd_addr  = r_rd_cnt[IDX_W-1:0];

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_key    = i_key[KEY_BITS-1:0];
                    n_rd_cnt = '0;
                    n_have   = 1'b0;
                    n_state  = (i_cmd == CMD_INSERT) ? S_VICT : S_LOOK;
                end
            end
            S_LOOK: begin
                if (r_cmp_vld) begin
                    if (cur_valid && cmp.key_eq) begin
                        mem_req.age_we = 1'b1;
                        n_res_hit  = 1'b1;
                        n_res_slot = r_cmp_idx;
                        pass_end   = 1'b1;
                        n_state    = S_DONE;
                    end else if (last) begin
                        n_res_hit  = 1'b0;
                        n_res_slot = '0;
                        pass_end   = 1'b1;
                        n_state    = S_DONE;
                    end
                end
            end
            S_VICT: begin
                if (r_cmp_vld) begin
                    if (!cur_valid) begin
                        n_best   = r_cmp_idx;
                        pass_end = 1'b1;
                    end else begin
                        if (sel_new) begin
                            n_best     = r_cmp_idx;
                            n_best_age = rd_age;
                            n_have     = 1'b1;
                        end
                        pass_end = last;
                    end
                    if (pass_end) begin
                        mem_req.key_we   = 1'b1;
                        mem_req.key_addr = n_best;
                        n_state          = S_AGE;
                    end
                end
            end
            S_AGE: begin
                if (r_cmp_vld) begin
                    if (r_cmp_idx == r_best) begin
                        mem_req.age_we = 1'b1;
                    end else if (cur_valid && cmp.age_nz) begin
                        mem_req.age_we   = 1'b1;
                        mem_req.age_data = cmp.age_dec;
                    end
                    if (last) begin
                        n_res_hit  = 1'b0;
                        n_res_slot = r_best;
                        pass_end   = 1'b1;
                        n_state    = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_res_hit;
                    n_out_slot  = SLOT_W'(r_res_slot);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        mem_req.rd_en = scanning && !pass_end && (r_rd_cnt < CNT_W'(ENTRIES));
        n_cmp_vld     = mem_req.rd_en;
        if (mem_req.rd_en) begin
            n_rd_cnt  = r_rd_cnt + CNT_W'(1);
            n_cmp_idx = r_rd_cnt[IDX_W-1:0];
        end
        if (pass_end) begin
            n_rd_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
            r_fresh     <= FRESH_AGE_RESET;
        end else begin
            r_state     <= n_state;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_fresh <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_cnt   <= n_rd_cnt;
        r_cmp_idx  <= n_cmp_idx;
        r_key      <= n_key;
        r_have     <= n_have;
        r_best     <= n_best;
        r_best_age <= n_best_age;
        r_res_hit  <= n_res_hit;
        r_res_slot <= n_res_slot;
        r_out_hit  <= n_out_hit;
        r_out_slot <= n_out_slot;
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_slot      = r_out_slot;

endmodule

[rtl/core/tcd_checker.sv]
`timescale 1ns / 1ps

module tcd_checker
    import tcd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_hit,
    input logic [SLOT_W-1:0] o_slot
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_hit) && $stable(o_slot))
        else $error("stalled result word changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled while word in progress");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_slot <= SLOT_W'(ENTRIES - 1)))
        else $error("slot index out of range");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("handshake not cleared by reset");

endmodule

bind tagged_cache_directory_lru_core tcd_checker u_tcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_hit       (o_hit),
    .o_slot      (o_slot)
);
